>>> rtl/core/wtlfo_pkg.sv
`default_nettype none

package wtlfo_pkg;

	localparam int SAMPLE_W = 12;
	localparam int RATE_W = 12;
	localparam int TIDX_W = 8;
	localparam int MODE_W = 2;
	localparam int REF_W = 12;
	localparam int SCALE_W = 7;
	localparam int FRAC_W = 16;
	localparam int GAIN_W = 18;
	localparam int DELTA_W = 22;
	localparam int REFX_W = 19;
	localparam int SR_W = 19;
	localparam int PROD_W = 30;
	localparam int DVD_W = 36;
	localparam int TABLE_SIZE_DEF = 256;

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam int REG_W = 2;

	localparam logic [REG_W-1:0] REG_MODE = 2'd0;
	localparam logic [REG_W-1:0] REG_REF = 2'd1;
	localparam logic [REG_W-1:0] REG_SCALE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_BYPASS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TREMOLO = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PITCH = 2'd2;
	localparam logic [MODE_W-1:0] MODE_VIBRATO = 2'd3;

	localparam logic OP_PROCESS = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [MODE_W-1:0] MODE_RESET = MODE_BYPASS;
	localparam logic [REF_W-1:0] REF_RESET = 12'd4095;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 7'd2;

	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
	localparam logic [GAIN_W-1:0] VIB_HIGH = 18'd65536;
	localparam logic [GAIN_W-1:0] VIB_LOW = 18'd50332;
	localparam logic [GAIN_W-1:0] VIB_RESET = 18'd7602;
	localparam logic [GAIN_W-1:0] VIB_MAX = 18'd262143;
	localparam logic [SCALE_W-1:0] VIB_DIV = 7'd100;

	typedef struct packed {
		logic                operation;
		logic [RATE_W-1:0]   rate_control;
		logic [SAMPLE_W-1:0] sample_in;
		logic [TIDX_W-1:0]   table_index;
		logic [SAMPLE_W-1:0] table_value;
	} item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/wtlfo_if.sv
`default_nettype none

interface wtlfo_item_if;
	import wtlfo_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface wtlfo_result_if;
	import wtlfo_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/wavetable_lfo_modulator.sv
// A sample goes from S_MODE and S_SETUP straight to S_OUT in bypass; pitch average, tremolo
// and vibrato pass through the divider first, and any mode may wait for the output slot.
// Throughput: a table write is taken every cycle while the block is idle; the next word after a
// sample is taken in the cycle after that sample reaches the output slot. The 36-step
// restoring divider sets the busy time: it runs once in pitch and twice in tremolo and vibrato.
// Reset (arst_n low, asynchronous): phase 0, vibrato gain 7602 rising, registers at defaults.
`default_nettype none

module wavetable_lfo_modulator #(
	parameter int TABLE_SIZE = wtlfo_pkg::TABLE_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wtlfo_item_if.sink                    item,
	wtlfo_result_if.source                result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wtlfo_pkg::APB_AW-1:0]  paddr,
	input  logic [wtlfo_pkg::APB_DW-1:0]  pwdata,
	output logic [wtlfo_pkg::APB_DW-1:0]  prdata,
	output logic                          pready
);
	import wtlfo_pkg::*;

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int PH_W = IDX_W + FRAC_W;
	localparam int DVS_W = REFX_W;
	localparam int WA_W = (IDX_W > TIDX_W) ? IDX_W : TIDX_W;
	localparam int CNT_W = $clog2(DVD_W + 1);
	localparam int WRAP_W = DVD_W - FRAC_W;
	localparam logic [WRAP_W-1:0] WRAP_RECIP = WRAP_W'((1 << WRAP_W) / TABLE_SIZE);
	localparam logic [WRAP_W-1:0] WRAP_SIZE = WRAP_W'(TABLE_SIZE);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MODE = 4'd1;
	localparam logic [3:0] S_SETUP = 4'd2;
	localparam logic [3:0] S_DIV = 4'd3;
	localparam logic [3:0] S_POST = 4'd4;
	localparam logic [3:0] S_VMUL = 4'd5;
	localparam logic [3:0] S_VRES = 4'd6;
	localparam logic [3:0] S_OUT = 4'd7;
	localparam logic [3:0] S_WRAP1 = 4'd8;
	localparam logic [3:0] S_WRAP2 = 4'd9;
	localparam logic [3:0] S_WRAP3 = 4'd10;

	localparam logic [1:0] T_TREM = 2'd0;
	localparam logic [1:0] T_VIB = 2'd1;
	localparam logic [1:0] T_INC = 2'd2;

	function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [DVD_W-1:0] v);
		return (v > DVD_W'(SAMPLE_MAX)) ? SAMPLE_MAX : v[SAMPLE_W-1:0];
	endfunction

	// Configuration registers
	logic [MODE_W-1:0]  mode_q;
	logic [REF_W-1:0]   ref_q;
	logic [SCALE_W-1:0] scale_q;
	logic               apb_wr;
	logic [REG_W-1:0]   reg_sel;
	logic [REF_W-1:0]   ref_eff;

	// Control state
	logic [3:0]        state_q;
	logic [1:0]        tag_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PH_W-1:0]   phase_q;
	logic [GAIN_W-1:0] gain_q;
	logic              rising_q;
	logic              out_valid_q;

	// Datapath
	logic [SAMPLE_W-1:0] samp_q;
	logic [RATE_W-1:0]   rate_q;
	logic [SAMPLE_W-1:0] rd_q;
	logic [PROD_W-1:0]   prod_q;
	logic [REFX_W-1:0]   refx_q;
	logic [SR_W-1:0]     sr_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DVS_W-1:0]    dvs_q;
	logic [DVS_W-1:0]    rem_q;
	logic [SAMPLE_W-1:0] res_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic [WRAP_W-1:0]   wrap_qe_q;
	logic [WRAP_W-1:0]   wrap_r_q;

	logic [SAMPLE_W-1:0] wave_mem [TABLE_SIZE];

	logic                    item_acc;
	logic                    slot_free;
	logic                    tbl_we;
	logic                    tbl_re;
	logic [WA_W-1:0]         widx;
	logic [IDX_W-1:0]        waddr;
	logic [IDX_W-1:0]        raddr;
	logic [2*SAMPLE_W-1:0]   mul_st;
	logic [PROD_W-1:0]       mul_sv;
	logic [SR_W-1:0]         mul_sr;
	logic [REFX_W-1:0]       mul_rx;
	logic [DVD_W-1:0]        inc_dvd;
	logic [SAMPLE_W:0]       pitch_sum;
	logic [DVS_W:0]          rem_sh;
	logic                    q_bit;
	logic [DVS_W-1:0]        rem_nxt;
	logic [DELTA_W-1:0]      delta;
	logic [DELTA_W:0]        up_sum;
	logic [GAIN_W-1:0]       up_g;
	logic [GAIN_W-1:0]       dn_g;
	logic [WRAP_W-1:0]       wrap_y;
	logic [2*WRAP_W-1:0]     wrap_mul;
	logic [WRAP_W-1:0]       wrap_qt;
	logic [WRAP_W-1:0]       wrap_fix;

	// APB port
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign reg_sel = paddr[APB_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			ref_q <= REF_RESET;
			scale_q <= SCALE_RESET;
		end else if (apb_wr) begin
			unique case (reg_sel)
				REG_MODE: begin
					mode_q <= pwdata[MODE_W-1:0];
				end
				REG_REF: begin
					ref_q <= pwdata[REF_W-1:0];
				end
				REG_SCALE: begin
					scale_q <= pwdata[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_MODE: prdata = APB_DW'(mode_q);
			REG_REF: prdata = APB_DW'(ref_q);
			REG_SCALE: prdata = APB_DW'(scale_q);
			default: prdata = '0;
		endcase
	end

	// A reference of zero behaves as one.
	assign ref_eff = (ref_q == '0) ? REF_W'(1) : ref_q;

	// Handshakes
	assign item.ready = (state_q == S_IDLE);
	assign item_acc = item.valid && item.ready;
	assign slot_free = !out_valid_q || result.ready;
	assign result.valid = out_valid_q;
	assign result.data.sample_out = out_data_q;

	// Wavetable memory: writes beyond the table are dropped.
	assign widx = WA_W'(item.data.table_index);
	assign waddr = widx[IDX_W-1:0];
	assign raddr = phase_q[PH_W-1:FRAC_W];
	assign tbl_we = item_acc && (item.data.operation == OP_WRITE)
		&& ({1'b0, widx} < (WA_W + 1)'(TABLE_SIZE));
	assign tbl_re = item_acc && (item.data.operation == OP_PROCESS);

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			wave_mem[waddr] <= item.data.table_value;
		end
		if (tbl_re) begin
			rd_q <= wave_mem[raddr];
		end
	end

	// Multipliers, each registered before use
	assign mul_st = samp_q * rd_q;
	assign mul_sv = PROD_W'(samp_q) * PROD_W'(gain_q);
	assign mul_sr = SR_W'(scale_q) * SR_W'(rate_q);
	assign mul_rx = REFX_W'(ref_eff) * REFX_W'(VIB_DIV);

	assign inc_dvd = DVD_W'({sr_q, {FRAC_W{1'b0}}});
	assign pitch_sum = {1'b0, samp_q} + {1'b0, rd_q};

	// One restoring step: the quotient shifts in at the bottom of the dividend register.
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign q_bit = (rem_sh >= {1'b0, dvs_q});
	assign rem_nxt = q_bit ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];

	// Phase wrap: the integer part is reduced modulo the table size with a reciprocal
	// estimate that is at most one short, so a single correction finishes it.
	assign wrap_y = dvd_q[DVD_W-1:FRAC_W];
	assign wrap_mul = (2*WRAP_W)'(wrap_y) * (2*WRAP_W)'(WRAP_RECIP);
	assign wrap_qt = wrap_qe_q * WRAP_SIZE;
	assign wrap_fix = (wrap_r_q >= WRAP_SIZE) ? wrap_r_q - WRAP_SIZE : wrap_r_q;

	// Vibrato gain sweep
	assign delta = dvd_q[DELTA_W-1:0];
	assign up_sum = (DELTA_W + 1)'(gain_q) + (DELTA_W + 1)'(delta);
	assign up_g = (up_sum > (DELTA_W + 1)'(VIB_MAX)) ? VIB_MAX : up_sum[GAIN_W-1:0];
	always_comb begin
		dn_g = '0;
		if (DELTA_W'(gain_q) > delta) begin
			dn_g = GAIN_W'(DELTA_W'(gain_q) - delta);
		end
	end

	// Sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tag_q <= T_TREM;
			cnt_q <= '0;
			phase_q <= '0;
			gain_q <= VIB_RESET;
			rising_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (item_acc && item.data.operation == OP_PROCESS) begin
						state_q <= S_MODE;
					end
				end
				S_MODE: begin
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					cnt_q <= CNT_W'(DVD_W);
					case (mode_q)
						MODE_BYPASS: begin
							state_q <= S_OUT;
						end
						MODE_TREMOLO: begin
							tag_q <= T_TREM;
							state_q <= S_DIV;
						end
						MODE_PITCH: begin
							tag_q <= T_INC;
							state_q <= S_DIV;
						end
						default: begin
							tag_q <= T_VIB;
							state_q <= S_DIV;
						end
					endcase
				end
				S_DIV: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == CNT_W'(1)) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					cnt_q <= CNT_W'(DVD_W);
					case (tag_q)
						T_TREM: begin
							tag_q <= T_INC;
							state_q <= S_DIV;
						end
						T_VIB: begin
							if (rising_q) begin
								gain_q <= up_g;
								if (up_g >= VIB_HIGH) begin
									rising_q <= 1'b0;
								end
							end else begin
								gain_q <= dn_g;
								if (dn_g <= VIB_LOW) begin
									rising_q <= 1'b1;
								end
							end
							state_q <= S_VMUL;
						end
						default: begin
							state_q <= S_WRAP1;
						end
					endcase
				end
				S_VMUL: begin
					state_q <= S_VRES;
				end
				S_VRES: begin
					tag_q <= T_INC;
					cnt_q <= CNT_W'(DVD_W);
					state_q <= S_DIV;
				end
				S_WRAP1: begin
					state_q <= S_WRAP2;
				end
				S_WRAP2: begin
					state_q <= S_WRAP3;
				end
				S_WRAP3: begin
					phase_q <= {wrap_fix[IDX_W-1:0], dvd_q[FRAC_W-1:0]};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					samp_q <= item.data.sample_in;
					rate_q <= item.data.rate_control;
				end
			end
			S_MODE: begin
				prod_q <= PROD_W'(mul_st);
				refx_q <= mul_rx;
				sr_q <= mul_sr;
			end
			S_SETUP: begin
				rem_q <= '0;
				case (mode_q)
					MODE_BYPASS: begin
						res_q <= samp_q;
					end
					MODE_TREMOLO: begin
						dvd_q <= DVD_W'(prod_q);
						dvs_q <= DVS_W'(ref_eff);
					end
					MODE_PITCH: begin
						res_q <= pitch_sum[SAMPLE_W:1];
						dvd_q <= inc_dvd;
						dvs_q <= DVS_W'(ref_eff);
					end
					default: begin
						dvd_q <= DVD_W'({rd_q, {FRAC_W{1'b0}}});
						dvs_q <= DVS_W'(refx_q);
					end
				endcase
			end
			S_DIV: begin
				rem_q <= rem_nxt;
				dvd_q <= {dvd_q[DVD_W-2:0], q_bit};
			end
			S_POST: begin
				rem_q <= '0;
				case (tag_q)
					T_TREM: begin
						res_q <= sat_sample(dvd_q);
						dvd_q <= inc_dvd;
						dvs_q <= DVS_W'(ref_eff);
					end
					T_INC: begin
						// Phase plus step; the wrap at the table span follows.
						dvd_q <= DVD_W'(phase_q) + dvd_q;
					end
					default: begin
					end
				endcase
			end
			S_VMUL: begin
				prod_q <= mul_sv;
			end
			S_VRES: begin
				res_q <= sat_sample(DVD_W'(prod_q[PROD_W-1:FRAC_W]));
				rem_q <= '0;
				dvd_q <= inc_dvd;
				dvs_q <= DVS_W'(ref_eff);
			end
			S_WRAP1: begin
				wrap_qe_q <= wrap_mul[2*WRAP_W-1:WRAP_W];
			end
			S_WRAP2: begin
				wrap_r_q <= wrap_y - wrap_qt;
			end
			S_OUT: begin
				if (slot_free) begin
					out_data_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
